/* sv/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg: shared definitions for the pretrigger sample capture block
// Sizes, register and mode codes, state encoding and result types.
// ----------------------------------------------------------------------------
package psc_pkg;

  // history ring
  localparam int HIST_DEPTH = 32;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

  // row limit per trial
  localparam int MAX_ROWS = 256;
  localparam int ROWS_W   = $clog2(MAX_ROWS + 1);

  // field widths
  localparam int TIME_W = 32;
  localparam int DATA_W = 49;
  localparam int ENT_W  = TIME_W + DATA_W;
  localparam int IDX_W  = 8;
  localparam int CFG_W  = 16;

  // remainder unit
  localparam int DVD_W     = 32;
  localparam int DVS_W     = 16;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_DUMP_EN = 3'd0;
  localparam logic [2:0] REG_FIRST   = 3'd1;
  localparam logic [2:0] REG_NTH     = 3'd2;
  localparam logic [2:0] REG_LEAD    = 3'd3;
  localparam logic [2:0] REG_TAIL    = 3'd4;
  localparam logic [2:0] REG_STEP    = 3'd5;

  // item modes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_BEGIN  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // result kinds
  localparam logic KIND_ROW  = 1'b0;
  localparam logic KIND_WARN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_COMMIT,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] rel;
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  idx;
  } res_t;

  typedef struct packed {
    logic busy;
    logic rem_zero;
  } div_stat_t;

  // ring index wrap, value is below twice the depth
  function automatic logic [HIST_AW-1:0] wrap_idx(input logic [HIST_AW:0] v);
    logic [HIST_AW:0] r;
    r = v;
    if (v >= (HIST_AW+1)'(HIST_DEPTH)) begin
      r = v - (HIST_AW+1)'(HIST_DEPTH);
    end
    return r[HIST_AW-1:0];
  endfunction

endpackage

/* sv/psc_ram.sv */
// ----------------------------------------------------------------------------
// psc_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module psc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* sv/psc_div.sv */
// ----------------------------------------------------------------------------
// psc_div: bit-serial remainder unit
// Restoring division, one dividend bit per cycle, reports a zero remainder.
// ----------------------------------------------------------------------------
module psc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [psc_pkg::DVD_W-1:0] dividend_i,
  input  logic [psc_pkg::DVS_W-1:0] divisor_i,
  output psc_pkg::div_stat_t        stat_o
);

  logic [psc_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic [psc_pkg::DVD_W-1:0]  dvd_q, dvd_d;
  logic [psc_pkg::DVS_W-1:0]  dvs_q, dvs_d;
  logic [psc_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [psc_pkg::DVS_W:0]    shifted;

  // one restoring step
  always_comb begin
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    shifted = {rem_q, dvd_q[psc_pkg::DVD_W-1]};
    if (start_i) begin
      cnt_d = psc_pkg::DIV_CW'(psc_pkg::DIV_STEPS);
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = psc_pkg::DVS_W'(shifted - {1'b0, dvs_q});
      end else begin
        rem_d = shifted[psc_pkg::DVS_W-1:0];
      end
      dvd_d = {dvd_q[psc_pkg::DVD_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      dvd_q <= '0;
      dvs_q <= '0;
      rem_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      dvd_q <= dvd_d;
      dvs_q <= dvs_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy     = (cnt_q != '0);
  assign stat_o.rem_zero = (rem_q == '0);

endmodule

/* sv/pretrigger_sample_capture_core.sv */
// ----------------------------------------------------------------------------
// pretrigger_sample_capture_core: history trace with a pre-trigger window
// Collapses samples per millisecond, keeps a history ring and emits
// timestamped rows around a trial trigger.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A sample item is accepted, committed into
// the history memory and then its result is flushed. A begin item waits on
// the serial remainder unit to test the every-nth rule, then opens the
// window, commits the pending sample and, if the trial is captured, replays
// the history ring entry by entry through the registered read of the
// history memory, ends the walk and flushes. A clear item is handled as it
// is accepted. Each result waits for a free output register, so a stalled
// output holds the item back. The last result of an item carries last.
// ----------------------------------------------------------------------------
module pretrigger_sample_capture_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psc_pkg::PADDR_W-1:0] paddr,
  input  logic [psc_pkg::PDATA_W-1:0] pwdata,
  output logic [psc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [31:0]                 sample_ms_i,
  input  logic [15:0]                 level_now_i,
  input  logic [15:0]                 envelope_i,
  input  logic [15:0]                 peak_level_i,
  input  logic                        gate_open_i,
  input  logic [31:0]                 trial_number_i,
  input  logic [31:0]                 trigger_ms_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic signed [31:0]          rel_ms_o,
  output logic [15:0]                 row_level_o,
  output logic [15:0]                 row_envelope_o,
  output logic [15:0]                 row_peak_o,
  output logic                        row_open_o,
  output logic [7:0]                  row_index_o,
  output logic                        last_o
);

  localparam int TW = psc_pkg::TIME_W;
  localparam int DW = psc_pkg::DATA_W;
  localparam int AW = psc_pkg::HIST_AW;

  // configuration registers
  logic                     dump_en_q;
  logic [psc_pkg::CFG_W-1:0] first_q, nth_q, lead_q, tail_q, step_q;

  // item registers
  logic [1:0]    it_mode_q;
  logic [TW-1:0] it_ts_q, it_trial_q, it_trig_q;
  logic [DW-1:0] it_data_q;

  // capture state
  psc_pkg::state_e        state_q, state_d;
  logic                   pend_v_q;
  logic [TW-1:0]          pend_t_q;
  logic [DW-1:0]          pend_d_q;
  logic [AW-1:0]          head_q;
  logic [psc_pkg::FILL_W-1:0] fill_q, ridx_q;
  logic                   sel_q, cap_q, warned_q;
  logic [TW-1:0]          trig_q, ws_q, we_q, ne_q;
  logic [psc_pkg::ROWS_W-1:0] rows_q;

  // result staging and output register
  logic          stage_v_q, out_v_q, out_last_q;
  psc_pkg::res_t stage_q, out_q;

  // datapath controls
  logic                  accept, ofree;
  logic                  cm_do, cm_hit, cm_row, cm_warn;
  logic [TW-1:0]         cm_now;
  logic                  ev_ok, ev_row, ev_warn, ev_stop;
  logic [TW-1:0]         ev_t;
  logic [DW-1:0]         ev_d;
  logic                  new_v, flush;
  psc_pkg::res_t         new_res;
  logic [TW-1:0]         row_t;
  logic                  ram_we;
  logic [AW-1:0]         ram_wa, ram_ra;
  logic [psc_pkg::ENT_W-1:0] ram_rd;
  psc_pkg::div_stat_t    div_stat;
  logic                  first_sel, nth_sel;
  logic [TW-1:0]         lead_ext;
  logic                  cfg_we;

  assign accept = in_valid_i && in_ready_o;
  assign ofree  = !out_v_q || out_ready_i;
  assign in_ready_o = (state_q == psc_pkg::ST_IDLE);

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_en_q <= 1'b0;
      first_q   <= '0;
      nth_q     <= '0;
      lead_q    <= '0;
      tail_q    <= '0;
      step_q    <= '0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        psc_pkg::REG_DUMP_EN: dump_en_q <= pwdata[0];
        psc_pkg::REG_FIRST:   first_q   <= pwdata[psc_pkg::CFG_W-1:0];
        psc_pkg::REG_NTH:     nth_q     <= pwdata[psc_pkg::CFG_W-1:0];
        psc_pkg::REG_LEAD:    lead_q    <= pwdata[psc_pkg::CFG_W-1:0];
        psc_pkg::REG_TAIL:    tail_q    <= pwdata[psc_pkg::CFG_W-1:0];
        psc_pkg::REG_STEP:    step_q    <= pwdata[psc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      psc_pkg::REG_DUMP_EN: prdata = {31'd0, dump_en_q};
      psc_pkg::REG_FIRST:   prdata = {16'd0, first_q};
      psc_pkg::REG_NTH:     prdata = {16'd0, nth_q};
      psc_pkg::REG_LEAD:    prdata = {16'd0, lead_q};
      psc_pkg::REG_TAIL:    prdata = {16'd0, tail_q};
      psc_pkg::REG_STEP:    prdata = {16'd0, step_q};
      default:              prdata = '0;
    endcase
  end

  // every-nth remainder
  psc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && (mode_i == psc_pkg::MODE_BEGIN)),
    .dividend_i (trial_number_i),
    .divisor_i  (nth_q),
    .stat_o     (div_stat)
  );

  // history memory, time in the upper bits
  psc_ram #(
    .WIDTH (psc_pkg::ENT_W),
    .DEPTH (psc_pkg::HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i ({pend_t_q, pend_d_q}),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      psc_pkg::ST_IDLE: begin
        if (accept) begin
          if (mode_i == psc_pkg::MODE_SAMPLE) begin
            state_d = psc_pkg::ST_COMMIT;
          end else if (mode_i == psc_pkg::MODE_BEGIN) begin
            state_d = psc_pkg::ST_DIV;
          end
        end
      end
      psc_pkg::ST_DIV: begin
        if (!div_stat.busy) begin
          state_d = psc_pkg::ST_SETUP;
        end
      end
      psc_pkg::ST_SETUP: state_d = psc_pkg::ST_COMMIT;
      psc_pkg::ST_COMMIT: begin
        if (ofree) begin
          if (it_mode_q == psc_pkg::MODE_BEGIN && cap_q) begin
            state_d = psc_pkg::ST_READ;
          end else begin
            state_d = psc_pkg::ST_FLUSH;
          end
        end
      end
      psc_pkg::ST_READ: begin
        if (ridx_q == fill_q) begin
          state_d = psc_pkg::ST_FLUSH;
        end else begin
          state_d = psc_pkg::ST_EVAL;
        end
      end
      psc_pkg::ST_EVAL: begin
        if (ofree) begin
          state_d = ev_stop ? psc_pkg::ST_FLUSH : psc_pkg::ST_READ;
        end
      end
      psc_pkg::ST_FLUSH: begin
        if (ofree) begin
          state_d = psc_pkg::ST_IDLE;
        end
      end
      default: state_d = psc_pkg::ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    // selection and window
    lead_ext  = {16'd0, lead_q};
    first_sel = (first_q != '0) && (it_trial_q <= {16'd0, first_q});
    nth_sel   = (nth_q != '0) && div_stat.rem_zero;

    // commit of the pending sample
    cm_now  = (it_mode_q == psc_pkg::MODE_BEGIN) ? it_trig_q + 32'd1 : it_ts_q;
    cm_do   = (state_q == psc_pkg::ST_COMMIT) && ofree && pend_v_q && (pend_t_q < cm_now);
    cm_hit  = cm_do && cap_q && sel_q && (pend_t_q >= ws_q) && (pend_t_q <= we_q)
              && (pend_t_q >= ne_q);
    cm_row  = cm_hit && (rows_q < psc_pkg::ROWS_W'(psc_pkg::MAX_ROWS));
    cm_warn = cm_hit && !cm_row && !warned_q;

    ram_we = cm_do;
    if (fill_q < psc_pkg::FILL_W'(psc_pkg::HIST_DEPTH)) begin
      ram_wa = psc_pkg::wrap_idx((AW+1)'(head_q) + (AW+1)'(fill_q));
    end else begin
      ram_wa = head_q;
    end
    ram_ra = psc_pkg::wrap_idx((AW+1)'(head_q) + (AW+1)'(ridx_q));

    // replay of one history entry
    ev_t    = ram_rd[psc_pkg::ENT_W-1 -: TW];
    ev_d    = ram_rd[DW-1:0];
    ev_ok   = (ev_t >= ws_q) && (ev_t <= trig_q) && (ev_t >= ne_q);
    ev_row  = (state_q == psc_pkg::ST_EVAL) && ofree && ev_ok
              && (rows_q < psc_pkg::ROWS_W'(psc_pkg::MAX_ROWS));
    ev_warn = (state_q == psc_pkg::ST_EVAL) && ofree && ev_ok && !ev_row && !warned_q;
    ev_stop = (ev_t >= ws_q) && ((ev_t > trig_q) || (ev_ok && !ev_row && !warned_q));

    // new result
    new_v   = cm_row || cm_warn || ev_row || ev_warn;
    row_t   = (state_q == psc_pkg::ST_EVAL) ? ev_t : pend_t_q;
    new_res = '0;
    if (cm_row || ev_row) begin
      new_res.kind = psc_pkg::KIND_ROW;
      new_res.rel  = row_t - trig_q;
      new_res.data = (state_q == psc_pkg::ST_EVAL) ? ev_d : pend_d_q;
      new_res.idx  = psc_pkg::IDX_W'(rows_q);
    end else if (cm_warn || ev_warn) begin
      new_res.kind = psc_pkg::KIND_WARN;
    end
    flush = (state_q == psc_pkg::ST_FLUSH) && ofree && stage_v_q;
  end

  // capture state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= psc_pkg::ST_IDLE;
      pend_v_q <= 1'b0;
      pend_t_q <= '0;
      pend_d_q <= '0;
      head_q   <= '0;
      fill_q   <= '0;
      ridx_q   <= '0;
      sel_q    <= 1'b0;
      cap_q    <= 1'b0;
      warned_q <= 1'b0;
      trig_q   <= '0;
      ws_q     <= '0;
      we_q     <= '0;
      ne_q     <= '0;
      rows_q   <= '0;
    end else begin
      state_q <= state_d;

      // clear item
      if (accept && mode_i == psc_pkg::MODE_CLEAR) begin
        pend_v_q <= 1'b0;
        pend_t_q <= '0;
        pend_d_q <= '0;
        head_q   <= '0;
        fill_q   <= '0;
        sel_q    <= 1'b0;
        cap_q    <= 1'b0;
        trig_q   <= '0;
        ws_q     <= '0;
        we_q     <= '0;
        ne_q     <= '0;
        rows_q   <= '0;
      end

      // open the trial window
      if (state_q == psc_pkg::ST_SETUP) begin
        sel_q  <= dump_en_q && (first_sel || nth_sel);
        cap_q  <= dump_en_q && (first_sel || nth_sel);
        trig_q <= it_trig_q;
        if (it_trig_q > lead_ext) begin
          ws_q <= it_trig_q - lead_ext;
          ne_q <= it_trig_q - lead_ext;
        end else begin
          ws_q <= '0;
          ne_q <= '0;
        end
        we_q   <= it_trig_q + {16'd0, tail_q};
        rows_q <= '0;
        ridx_q <= '0;
      end

      // commit into the ring
      if (cm_do) begin
        if (fill_q < psc_pkg::FILL_W'(psc_pkg::HIST_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end else begin
          head_q <= psc_pkg::wrap_idx((AW+1)'(head_q) + (AW+1)'(1));
        end
      end

      // pending sample, replaced by a sample item or emptied by a commit
      if (state_q == psc_pkg::ST_COMMIT && ofree && it_mode_q == psc_pkg::MODE_SAMPLE) begin
        pend_v_q <= 1'b1;
        pend_t_q <= it_ts_q;
        pend_d_q <= it_data_q;
      end else if (cm_do) begin
        pend_v_q <= 1'b0;
        pend_t_q <= '0;
        pend_d_q <= '0;
      end

      // row bookkeeping
      if (cm_row || ev_row) begin
        rows_q <= rows_q + 1'b1;
        ne_q   <= row_t + {16'd0, step_q};
      end
      if (cm_warn || ev_warn) begin
        warned_q <= 1'b1;
      end
      if ((cm_hit && !cm_row) || ev_warn) begin
        cap_q <= 1'b0;
      end

      // replay walk
      if (state_q == psc_pkg::ST_EVAL && ofree) begin
        ridx_q <= ridx_q + 1'b1;
      end
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_mode_q  <= mode_i;
      it_ts_q    <= sample_ms_i;
      it_data_q  <= {gate_open_i, peak_level_i, envelope_i, level_now_i};
      it_trial_q <= trial_number_i;
      it_trig_q  <= trigger_ms_i;
    end
  end

  // result staging, held back one so the final one can carry last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q  <= 1'b0;
      stage_q    <= '0;
      out_v_q    <= 1'b0;
      out_q      <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (flush) begin
        out_q      <= stage_q;
        out_last_q <= 1'b1;
        out_v_q    <= 1'b1;
        stage_v_q  <= 1'b0;
      end else if (new_v) begin
        if (stage_v_q) begin
          out_q      <= stage_q;
          out_last_q <= 1'b0;
          out_v_q    <= 1'b1;
        end else if (out_ready_i) begin
          out_v_q <= 1'b0;
        end
        stage_q   <= new_res;
        stage_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // output ports
  assign out_valid_o    = out_v_q;
  assign kind_o         = out_q.kind;
  assign rel_ms_o       = signed'(out_q.rel);
  assign row_level_o    = out_q.data[15:0];
  assign row_envelope_o = out_q.data[31:16];
  assign row_peak_o     = out_q.data[47:32];
  assign row_open_o     = out_q.data[48];
  assign row_index_o    = out_q.idx;
  assign last_o         = out_last_q;

`ifndef SYNTHESIS
  // no result stays staged once an item is done
  a_stage_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psc_pkg::ST_IDLE) |-> !stage_v_q)
    else $error("staged result left behind at idle");

  // history fill never passes the ring depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= psc_pkg::FILL_W'(psc_pkg::HIST_DEPTH))
    else $error("history fill beyond depth");

  // row count never passes the limit
  a_rows_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q <= psc_pkg::ROWS_W'(psc_pkg::MAX_ROWS))
    else $error("row count beyond limit");

  // the warning flag is sticky, even through a clear item
  a_warned_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warned_q |=> warned_q)
    else $error("warning flag dropped");
`endif

endmodule
